// File: src/corq_pkg.sv
// shared constants and codes for the credit ordered run queue
package corq_pkg;

  localparam int MAX_TASKS = 64;
  localparam int PRIO_BITS = 8;
  localparam int ID_SPACE  = 64;

  localparam int ID_W   = $clog2(ID_SPACE);
  localparam int ADDR_W = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_TICK   = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

// File: src/corq_ram.sv
// simple dual port ram, one write port and one registered read port
module corq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/credit_ordered_run_queue.sv
// Run queue of task ids ordered by credit, with per-task priority and credit.
// An item is taken when start is high and busy is low; busy stays high until
// the operation is done, and the result is shown for exactly one cycle with
// out_valid high, in the same cycle in which busy drops. The receiver cannot
// stall, so it must take the result in that cycle. One operation walks the
// queue through the single read port of the order memory and of the credit
// memory: an add steps ADD_ORD, ADD_CRED, ADD_CMP per entry it passes and
// ADD_SHIFT, ADD_SHIFT_WR per entry it shifts, a remove REM_ORD, REM_CMP then
// REM_SHIFT, REM_SHIFT_WR, a tick TICK_ORD, TICK_CRED, TICK_CMP per entry.
module credit_ordered_run_queue
  import corq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_func,
  input  logic [5:0] in_task_id,
  input  logic [7:0] in_task_priority,
  output logic       out_valid,
  output logic [5:0] out_head_task,
  output logic       out_switched,
  output logic [6:0] out_queue_count,
  output logic [1:0] out_status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_ORD,
    S_ADD_CRED,
    S_ADD_CMP,
    S_ADD_SHIFT,
    S_ADD_SHIFT_WR,
    S_REM_ORD,
    S_REM_CMP,
    S_REM_SHIFT,
    S_REM_SHIFT_WR,
    S_TICK_PRIO,
    S_TICK_ORD,
    S_TICK_CRED,
    S_TICK_CMP,
    S_FIN
  } state_t;

  state_t               state_r;
  func_t                func_r;
  status_t              status_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     idx_r;
  logic [ID_W-1:0]      id_r;
  logic [PRIO_BITS-1:0] prio_r;
  logic [ID_W-1:0]      carry_r;
  logic [ID_W-1:0]      t_r;
  logic [ID_W-1:0]      cur_r;
  logic [PRIO_BITS-1:0] cur_cred_r;
  logic [ID_W-1:0]      head_r;
  logic [ID_W-1:0]      old_head_r;

  logic                 out_valid_r;
  logic [5:0]           out_head_r;
  logic                 out_switched_r;
  logic [6:0]           out_count_r;
  status_t              out_status_r;

  // memory ports
  logic                 ord_we;
  logic [ADDR_W-1:0]    ord_waddr;
  logic [ID_W-1:0]      ord_wdata;
  logic [ADDR_W-1:0]    ord_raddr;
  logic [ID_W-1:0]      ord_q;
  logic                 cred_we;
  logic [ID_W-1:0]      cred_waddr;
  logic [PRIO_BITS-1:0] cred_wdata;
  logic [ID_W-1:0]      cred_raddr;
  logic [PRIO_BITS-1:0] cred_q;
  logic                 prio_we;
  logic [ID_W-1:0]      prio_raddr;
  logic [PRIO_BITS-1:0] prio_q;

  logic [PRIO_BITS-1:0] in_prio;
  logic [CNT_W-1:0]     idx_p1;
  logic [CNT_W-1:0]     idx_m1;
  logic                 at_end;
  logic                 is_full;
  logic                 accept;
  logic                 add_found;
  logic                 tick_found;

  assign in_prio    = PRIO_BITS'(in_task_priority);
  assign idx_p1     = idx_r + CNT_W'(1);
  assign idx_m1     = idx_r - CNT_W'(1);
  assign at_end     = (idx_r == count_r);
  assign is_full    = (count_r == CNT_W'(MAX_TASKS));
  assign accept     = start && (state_r == S_IDLE);
  assign add_found  = (cred_q > prio_r);
  assign tick_found = (cred_q > cur_cred_r);

  corq_ram #(.WIDTH(ID_W), .DEPTH(MAX_TASKS)) u_order (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_q)
  );

  corq_ram #(.WIDTH(PRIO_BITS), .DEPTH(ID_SPACE)) u_credit (
    .clk   (clk),
    .we    (cred_we),
    .waddr (cred_waddr),
    .wdata (cred_wdata),
    .raddr (cred_raddr),
    .rdata (cred_q)
  );

  corq_ram #(.WIDTH(PRIO_BITS), .DEPTH(ID_SPACE)) u_prio (
    .clk   (clk),
    .we    (prio_we),
    .waddr (in_task_id),
    .wdata (in_prio),
    .raddr (prio_raddr),
    .rdata (prio_q)
  );

  always_comb begin
    ord_we     = 1'b0;
    ord_waddr  = idx_r[ADDR_W-1:0];
    ord_wdata  = carry_r;
    ord_raddr  = idx_r[ADDR_W-1:0];
    cred_we    = 1'b0;
    cred_waddr = in_task_id;
    cred_wdata = in_prio;
    cred_raddr = ord_q;
    prio_we    = 1'b0;
    prio_raddr = head_r;
    case (state_r)
      S_IDLE: begin
        if (accept && func_t'(in_func) == FN_ADD && !is_full) begin
          cred_we = 1'b1;
          prio_we = 1'b1;
        end
      end
      S_ADD_ORD, S_ADD_SHIFT: begin
        ord_we = at_end;
      end
      S_ADD_CMP: begin
        ord_we = add_found;
      end
      S_ADD_SHIFT_WR: begin
        ord_we = 1'b1;
      end
      S_REM_SHIFT: begin
        ord_raddr = idx_p1[ADDR_W-1:0];
      end
      S_REM_SHIFT_WR: begin
        ord_we    = 1'b1;
        ord_wdata = ord_q;
      end
      S_TICK_PRIO: begin
        cred_we    = 1'b1;
        cred_waddr = cur_r;
        cred_wdata = prio_q;
      end
      S_TICK_ORD: begin
        ord_we    = at_end;
        ord_waddr = idx_m1[ADDR_W-1:0];
        ord_wdata = cur_r;
      end
      S_TICK_CMP: begin
        ord_we    = 1'b1;
        ord_waddr = idx_m1[ADDR_W-1:0];
        if (tick_found) begin
          ord_wdata  = cur_r;
          cred_we    = 1'b1;
          cred_waddr = t_r;
          cred_wdata = cred_q - PRIO_BITS'(1);
        end else begin
          ord_wdata = t_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      // shadow copy of the queue head
      if (ord_we && ord_waddr == '0) begin
        head_r <= ord_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r     <= func_t'(in_func);
            id_r       <= in_task_id;
            prio_r     <= in_prio;
            carry_r    <= in_task_id;
            cur_r      <= head_r;
            old_head_r <= head_r;
            idx_r      <= '0;
            status_r   <= ST_OK;
            case (func_t'(in_func))
              FN_ADD: begin
                if (is_full) begin
                  status_r <= ST_FULL;
                  state_r  <= S_FIN;
                end else begin
                  state_r <= S_ADD_ORD;
                end
              end
              FN_REMOVE: begin
                state_r <= S_REM_ORD;
              end
              FN_TICK: begin
                if (count_r == '0) begin
                  status_r <= ST_EMPTY;
                  state_r  <= S_FIN;
                end else begin
                  idx_r   <= CNT_W'(1);
                  state_r <= S_TICK_PRIO;
                end
              end
              default: begin
                state_r <= S_FIN;
              end
            endcase
          end
        end
        S_ADD_ORD, S_ADD_SHIFT: begin
          if (at_end) begin
            count_r <= count_r + CNT_W'(1);
            state_r <= S_FIN;
          end else if (state_r == S_ADD_ORD) begin
            state_r <= S_ADD_CRED;
          end else begin
            state_r <= S_ADD_SHIFT_WR;
          end
        end
        S_ADD_CRED: begin
          t_r     <= ord_q;
          state_r <= S_ADD_CMP;
        end
        S_ADD_CMP: begin
          idx_r <= idx_p1;
          if (add_found) begin
            carry_r <= t_r;
            state_r <= S_ADD_SHIFT;
          end else begin
            state_r <= S_ADD_ORD;
          end
        end
        S_ADD_SHIFT_WR: begin
          carry_r <= ord_q;
          idx_r   <= idx_p1;
          state_r <= S_ADD_SHIFT;
        end
        S_REM_ORD: begin
          if (at_end) begin
            status_r <= ST_NOT_FOUND;
            state_r  <= S_FIN;
          end else begin
            state_r <= S_REM_CMP;
          end
        end
        S_REM_CMP: begin
          if (ord_q == id_r) begin
            state_r <= S_REM_SHIFT;
          end else begin
            idx_r   <= idx_p1;
            state_r <= S_REM_ORD;
          end
        end
        S_REM_SHIFT: begin
          if (idx_p1 == count_r) begin
            count_r <= count_r - CNT_W'(1);
            state_r <= S_FIN;
          end else begin
            state_r <= S_REM_SHIFT_WR;
          end
        end
        S_REM_SHIFT_WR: begin
          idx_r   <= idx_p1;
          state_r <= S_REM_SHIFT;
        end
        S_TICK_PRIO: begin
          cur_cred_r <= prio_q;
          state_r    <= S_TICK_ORD;
        end
        S_TICK_ORD: begin
          // no later entry qualified: old head already written at the tail
          if (at_end) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_TICK_CRED;
          end
        end
        S_TICK_CRED: begin
          t_r     <= ord_q;
          state_r <= S_TICK_CMP;
        end
        S_TICK_CMP: begin
          if (tick_found) begin
            state_r <= S_FIN;
          end else begin
            idx_r   <= idx_p1;
            state_r <= S_TICK_ORD;
          end
        end
        S_FIN: begin
          out_valid_r    <= 1'b1;
          out_head_r     <= (count_r == '0) ? '0 : head_r;
          out_switched_r <= (func_r == FN_TICK) && (status_r == ST_OK) &&
                            (head_r != old_head_r);
          out_count_r    <= 7'(count_r);
          out_status_r   <= status_r;
          state_r        <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_head_task   = out_head_r;
  assign out_switched    = out_switched_r;
  assign out_queue_count = out_count_r;
  assign out_status      = out_status_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_TASKS))
    else $error("queue count above capacity");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  a_result_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_FIN) && !busy)
    else $error("result strobe outside completion");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> count_r == CNT_W'(MAX_TASKS))
    else $error("full status with room left");

  a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_switched) |-> out_status == ST_OK && out_queue_count != '0)
    else $error("switch flagged on failed or empty tick");

endmodule
